>>> design/absm_pkg.sv
// ----------------------------------------------------------------------------
// absm_pkg: shared types and constants of the A/B boot slot manager
// Command and status codes, slot numbers, register indexes, default versions
// and the structs that pass between the top level and the command core.
// ----------------------------------------------------------------------------
package absm_pkg;

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    CMD_GET_INFO = 2'd0,
    CMD_ACTIVATE = 2'd1,
    CMD_ROLLBACK = 2'd2,
    CMD_BOOT_SEL = 2'd3
  } absm_cmd_e;

  // Status codes of a result beat
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_BAD_SLOT  = 2'd1;
  localparam logic [1:0] STS_INVALID   = 2'd2;

  // Slot numbers
  localparam logic [1:0] SLOT_NONE = 2'd0;
  localparam logic [1:0] SLOT_ONE  = 2'd1;
  localparam logic [1:0] SLOT_TWO  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRAM_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRAM_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_END = 3'd4;

  // Default versions applied on the first command
  localparam logic [31:0] VERSION_ONE_DEFAULT = 32'h0001_0000;
  localparam logic [31:0] VERSION_TWO_DEFAULT = 32'h0002_0000;

  typedef struct packed {
    logic [31:0] sram_low;
    logic [31:0] sram_high;
    logic [31:0] one_base;
    logic [31:0] two_base;
    logic [31:0] flash_limit;
  } absm_cfg_t;

  localparam absm_cfg_t CFG_RESET = '{
    sram_low:    32'h2000_0000,
    sram_high:   32'h2001_FFFF,
    one_base:    32'h0801_0000,
    two_base:    32'h0802_0000,
    flash_limit: 32'h0808_0000
  };

  typedef struct packed {
    absm_cmd_e   command;
    logic [7:0]  slot_req;
    logic [31:0] new_version;
    logic [31:0] one_stack_word;
    logic [31:0] one_entry_word;
    logic [31:0] two_stack_word;
    logic [31:0] two_entry_word;
  } absm_cmd_t;

  typedef struct packed {
    logic [1:0]  active;
    logic [1:0]  previous;
    logic        one_state;
    logic        two_state;
    logic [31:0] one_version;
    logic [31:0] two_version;
    logic [31:0] updates;
    logic        defaults_done;
  } absm_state_t;

  localparam absm_state_t STATE_RESET = '{
    active:        SLOT_ONE,
    previous:      SLOT_NONE,
    one_state:     1'b0,
    two_state:     1'b0,
    one_version:   32'd0,
    two_version:   32'd0,
    updates:       32'd1,
    defaults_done: 1'b0
  };

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  current_slot;
    logic [1:0]  former_slot;
    logic        one_valid;
    logic        two_valid;
    logic [31:0] one_version;
    logic [31:0] two_version;
    logic [31:0] updates;
    logic [1:0]  oldest;
    logic        can_roll_back;
    logic [31:0] boot_address;
  } absm_result_t;

endpackage

>>> design/absm_cmd_core.sv
// ----------------------------------------------------------------------------
// absm_cmd_core: command logic of the A/B boot slot manager
// Checks both slots, applies the defaults on the first command, executes one
// command and returns the next slot table and the result beat.
// ----------------------------------------------------------------------------
module absm_cmd_core (
  input  absm_pkg::absm_cfg_t    cfg_i,
  input  absm_pkg::absm_cmd_t    cmd_i,
  input  absm_pkg::absm_state_t  state_i,
  output absm_pkg::absm_state_t  state_o,
  output absm_pkg::absm_result_t result_o
);

  logic                  one_ok;
  logic                  two_ok;
  logic                  target_ok;
  logic [1:0]            rb_dest;
  logic [1:0]            status;
  logic [1:0]            oldest;
  logic [31:0]           boot_addr;
  absm_pkg::absm_state_t eff;
  absm_pkg::absm_state_t nxt;

  // Check vector words of both slots against SRAM and flash windows
  assign one_ok = (cmd_i.one_stack_word >= cfg_i.sram_low) &&
                  (cmd_i.one_stack_word <= cfg_i.sram_high) &&
                  (cmd_i.one_entry_word >= cfg_i.one_base) &&
                  (cmd_i.one_entry_word <  cfg_i.flash_limit);
  assign two_ok = (cmd_i.two_stack_word >= cfg_i.sram_low) &&
                  (cmd_i.two_stack_word <= cfg_i.sram_high) &&
                  (cmd_i.two_entry_word >= cfg_i.two_base) &&
                  (cmd_i.two_entry_word <  cfg_i.flash_limit);

  // Apply defaults ahead of the very first command
  always_comb begin
    eff = state_i;
    if (!state_i.defaults_done) begin
      eff.active        = absm_pkg::SLOT_ONE;
      eff.previous      = absm_pkg::SLOT_NONE;
      eff.one_state     = one_ok;
      eff.two_state     = two_ok;
      eff.one_version   = one_ok ? absm_pkg::VERSION_ONE_DEFAULT : 32'd0;
      eff.two_version   = two_ok ? absm_pkg::VERSION_TWO_DEFAULT : 32'd0;
      eff.updates       = 32'd1;
      eff.defaults_done = 1'b1;
    end
  end

  // Pick the rollback destination; none means rollback is impossible
  always_comb begin
    priority if (eff.previous == absm_pkg::SLOT_ONE && one_ok) begin
      rb_dest = absm_pkg::SLOT_ONE;
    end else if (eff.previous == absm_pkg::SLOT_TWO && two_ok) begin
      rb_dest = absm_pkg::SLOT_TWO;
    end else if (eff.active == absm_pkg::SLOT_ONE && two_ok) begin
      rb_dest = absm_pkg::SLOT_TWO;
    end else if (eff.active == absm_pkg::SLOT_TWO && one_ok) begin
      rb_dest = absm_pkg::SLOT_ONE;
    end else begin
      rb_dest = absm_pkg::SLOT_NONE;
    end
  end

  assign target_ok = (cmd_i.slot_req == 8'd1) ? one_ok : two_ok;

  // Execute the command
  always_comb begin
    nxt       = eff;
    status    = absm_pkg::STS_OK;
    oldest    = absm_pkg::SLOT_NONE;
    boot_addr = 32'd0;
    unique case (cmd_i.command)
      absm_pkg::CMD_GET_INFO: begin
        nxt.one_state = one_ok;
        nxt.two_state = two_ok;
        priority if (!one_ok) begin
          oldest = absm_pkg::SLOT_ONE;
        end else if (!two_ok) begin
          oldest = absm_pkg::SLOT_TWO;
        end else if (eff.one_version <= eff.two_version &&
                     eff.active != absm_pkg::SLOT_ONE) begin
          oldest = absm_pkg::SLOT_ONE;
        end else if (eff.two_version < eff.one_version &&
                     eff.active != absm_pkg::SLOT_TWO) begin
          oldest = absm_pkg::SLOT_TWO;
        end else begin
          oldest = (eff.active == absm_pkg::SLOT_ONE) ? absm_pkg::SLOT_TWO
                                                      : absm_pkg::SLOT_ONE;
        end
      end
      absm_pkg::CMD_ACTIVATE: begin
        priority if (cmd_i.slot_req != 8'd1 && cmd_i.slot_req != 8'd2) begin
          status = absm_pkg::STS_BAD_SLOT;
        end else if (!target_ok) begin
          status = absm_pkg::STS_INVALID;
        end else begin
          nxt.previous = eff.active;
          nxt.active   = cmd_i.slot_req[1:0];
          nxt.updates  = eff.updates + 32'd1;
          if (cmd_i.slot_req == 8'd1) begin
            nxt.one_state   = 1'b1;
            nxt.one_version = cmd_i.new_version;
          end else begin
            nxt.two_state   = 1'b1;
            nxt.two_version = cmd_i.new_version;
          end
        end
      end
      absm_pkg::CMD_ROLLBACK: begin
        if (rb_dest == absm_pkg::SLOT_NONE) begin
          status = absm_pkg::STS_BAD_SLOT;
        end else begin
          nxt.previous = eff.active;
          nxt.active   = rb_dest;
          nxt.updates  = eff.updates + 32'd1;
        end
      end
      absm_pkg::CMD_BOOT_SEL: begin
        priority if (eff.active == absm_pkg::SLOT_TWO && two_ok) begin
          boot_addr = cfg_i.two_base;
        end else if (one_ok) begin
          boot_addr = cfg_i.one_base;
        end else if (two_ok) begin
          boot_addr = cfg_i.two_base;
        end else begin
          boot_addr = 32'd0;
        end
      end
      default: begin
        nxt = eff;
      end
    endcase
  end

  // Assemble the result beat from the updated table
  always_comb begin
    result_o.status        = status;
    result_o.current_slot  = nxt.active;
    result_o.former_slot   = nxt.previous;
    result_o.one_valid     = nxt.one_state;
    result_o.two_valid     = nxt.two_state;
    result_o.one_version   = nxt.one_version;
    result_o.two_version   = nxt.two_version;
    result_o.updates       = nxt.updates;
    result_o.oldest        = oldest;
    result_o.can_roll_back = (cmd_i.command == absm_pkg::CMD_GET_INFO) &&
                             (rb_dest != absm_pkg::SLOT_NONE);
    result_o.boot_address  = boot_addr;
  end

  assign state_o = nxt;

endmodule

>>> design/ab_boot_slot_manager.sv
// ----------------------------------------------------------------------------
// ab_boot_slot_manager: two-slot firmware boot manager with rollback
// Input register, combinational command core and result register.
// ----------------------------------------------------------------------------
// One command beat is accepted per clock cycle while in_ready_o is high; the
// beat is captured in the input register, the combinational command core
// executes it and updates the slot table as it moves into the result
// register, and the result register holds the answer until taken. The
// rate of one beat per cycle holds while results are taken; a stalled
// result holds the command stage, and in_ready_o drops only when both
// stages are full.
// Configuration writes take effect at once and are meant for idle time.
// ----------------------------------------------------------------------------
module ab_boot_slot_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // command channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  slot_req_i,
  input  logic [31:0] new_version_i,
  input  logic [31:0] one_stack_word_i,
  input  logic [31:0] one_entry_word_i,
  input  logic [31:0] two_stack_word_i,
  input  logic [31:0] two_entry_word_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  current_slot_o,
  output logic [1:0]  former_slot_o,
  output logic        one_valid_o,
  output logic        two_valid_o,
  output logic [31:0] one_version_o,
  output logic [31:0] two_version_o,
  output logic [31:0] updates_o,
  output logic [1:0]  oldest_o,
  output logic        can_roll_back_o,
  output logic [31:0] boot_address_o
);

  absm_pkg::absm_cfg_t    cfg_q;
  absm_pkg::absm_cmd_t    cmd_q;
  logic                   cmd_valid_q;
  absm_pkg::absm_state_t  state_q;
  absm_pkg::absm_state_t  state_d;
  absm_pkg::absm_result_t res_d;
  absm_pkg::absm_result_t res_q;
  logic                   res_valid_q;
  logic                   advance;
  logic                   in_take;

  // Move the command stage on when the result register is free or draining
  assign advance    = cmd_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !cmd_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= absm_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        absm_pkg::CFG_SRAM_LOW:  cfg_q.sram_low    <= cfg_data_i;
        absm_pkg::CFG_SRAM_HIGH: cfg_q.sram_high   <= cfg_data_i;
        absm_pkg::CFG_ONE_BASE:  cfg_q.one_base    <= cfg_data_i;
        absm_pkg::CFG_TWO_BASE:  cfg_q.two_base    <= cfg_data_i;
        absm_pkg::CFG_FLASH_END: cfg_q.flash_limit <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Capture an input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (in_take) begin
      cmd_valid_q <= 1'b1;
    end else if (advance) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q.command        <= absm_pkg::absm_cmd_e'(command_i);
      cmd_q.slot_req       <= slot_req_i;
      cmd_q.new_version    <= new_version_i;
      cmd_q.one_stack_word <= one_stack_word_i;
      cmd_q.one_entry_word <= one_entry_word_i;
      cmd_q.two_stack_word <= two_stack_word_i;
      cmd_q.two_entry_word <= two_entry_word_i;
    end
  end

  absm_cmd_core u_core (
    .cfg_i    (cfg_q),
    .cmd_i    (cmd_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Commit the slot table as the command executes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= absm_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign status_o        = res_q.status;
  assign current_slot_o  = res_q.current_slot;
  assign former_slot_o   = res_q.former_slot;
  assign one_valid_o     = res_q.one_valid;
  assign two_valid_o     = res_q.two_valid;
  assign one_version_o   = res_q.one_version;
  assign two_version_o   = res_q.two_version;
  assign updates_o       = res_q.updates;
  assign oldest_o        = res_q.oldest;
  assign can_roll_back_o = res_q.can_roll_back;
  assign boot_address_o  = res_q.boot_address;

endmodule
